@@ src/tlf_pkg.sv @@
// ----------------------------------------------------------------------------
// tlf_pkg
// Shared constants for the text line folder: character codes, input modes,
// default line width and command queue depth.
// ----------------------------------------------------------------------------
package tlf_pkg;

	// Character codes
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// Input item modes
	localparam logic MODE_DATA  = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	// Default line width
	localparam int LINE_WIDTH_DEF = 63;

	// Number of chunk commands between front and back
	localparam int CMDQ_DEPTH = 2;

endpackage

@@ src/tlf_if.sv @@
// ----------------------------------------------------------------------------
// tlf_if
// Valid/ready channels of the text line folder: input bytes and output bytes.
// ----------------------------------------------------------------------------
interface tlf_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] in_byte;

	modport source (output valid, output mode, output in_byte, input ready);
	modport sink   (input valid, input mode, input in_byte, output ready);
endinterface

interface tlf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_end;

	modport source (output valid, output out_byte, output run_end, input ready);
	modport sink   (input valid, input out_byte, input run_end, output ready);
endinterface

@@ src/tlf_front.sv @@
// ----------------------------------------------------------------------------
// tlf_front
// Accepts input transfers, writes data bytes into the current buffer bank,
// tracks the fold point and issues one drain command per finished chunk.
// ----------------------------------------------------------------------------
module tlf_front #(
	parameter int  LINE_WIDTH = tlf_pkg::LINE_WIDTH_DEF,
	parameter type cmd_t      = logic,
	parameter type mem_wr_t   = logic
) (
	input  logic    clk,
	input  logic    arst_n,
	tlf_in_if.sink  in_ch,
	input  logic    q_full,
	output logic    push,
	output cmd_t    push_cmd,
	output mem_wr_t mem_wr
);

	localparam int AW = $clog2(LINE_WIDTH);
	localparam int CW = $clog2(LINE_WIDTH + 1);

	logic [AW-1:0] fill_q;
	logic [AW-1:0] blank_pos_q;
	logic          blank_seen_q;
	logic          bank_q;

	logic          accept;
	logic          is_data;
	logic [CW-1:0] fill_n;
	logic          full;
	logic          is_blank;
	logic          blank_seen_n;
	logic [AW-1:0] blank_pos_n;
	logic          chunk_end;

	// Input handshake: room for one more chunk command
	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;

	// Classify the byte
	assign is_data      = (in_ch.mode == tlf_pkg::MODE_DATA);
	assign fill_n       = CW'(fill_q) + CW'(1);
	assign full         = (fill_n == CW'(LINE_WIDTH));
	assign is_blank     = ((in_ch.in_byte == tlf_pkg::CH_SPACE) ||
	                       (in_ch.in_byte == tlf_pkg::CH_TAB)) && (fill_q != '0);
	assign blank_seen_n = blank_seen_q || is_blank;
	assign blank_pos_n  = is_blank ? fill_q : blank_pos_q;
	assign chunk_end    = is_data ? ((in_ch.in_byte == tlf_pkg::CH_NL) || full) : 1'b1;

	// Drain command for the chunk that ends with this transfer
	assign push = accept && chunk_end;

	always_comb begin
		push_cmd          = '0;
		push_cmd.bank     = bank_q;
		push_cmd.len      = is_data ? fill_n : CW'(fill_q);
		push_cmd.fold     = is_data && full && blank_seen_n;
		push_cmd.fold_pos = CW'(blank_pos_n);
		push_cmd.add_nl   = is_data && full && !blank_seen_n;
	end

	// Buffer write port
	always_comb begin
		mem_wr      = '0;
		mem_wr.en   = accept && is_data;
		mem_wr.addr = {bank_q, fill_q};
		mem_wr.data = in_ch.in_byte;
	end

	// Chunk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			blank_pos_q  <= '0;
			blank_seen_q <= 1'b0;
			bank_q       <= 1'b0;
		end else if (push) begin
			fill_q       <= '0;
			blank_pos_q  <= '0;
			blank_seen_q <= 1'b0;
			bank_q       <= !bank_q;
		end else if (accept) begin
			fill_q       <= fill_n[AW-1:0];
			blank_pos_q  <= blank_pos_n;
			blank_seen_q <= blank_seen_n;
		end
	end

	// A chunk never holds a full line between transfers
	a_fill_below_width: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(fill_q) < CW'(LINE_WIDTH))
		else $error("chunk fill reached line width without a drain command");

	// A blank position is only recorded past the first entry
	a_blank_pos_valid: assert property (@(posedge clk) disable iff (!arst_n)
		blank_seen_q |-> (blank_pos_q != '0) && (blank_pos_q < fill_q))
		else $error("recorded blank position outside the current chunk");

endmodule

@@ src/tlf_cmdq.sv @@
// ----------------------------------------------------------------------------
// tlf_cmdq
// Short FIFO of chunk drain commands; the head stays in place until the back
// end has finished draining that chunk.
// ----------------------------------------------------------------------------
module tlf_cmdq #(
	parameter type cmd_t = logic
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic full,
	output logic empty
);

	localparam int DEPTH = tlf_pkg::CMDQ_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW    = $clog2(DEPTH + 1);

	cmd_t          entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;

	assign full  = (count_q == NW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = entries_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + NW'(1);
				2'b01:   count_q <= count_q - NW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("command pushed into a full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("command popped from an empty queue");

endmodule

@@ src/tlf_back.sv @@
// ----------------------------------------------------------------------------
// tlf_back
// Holds the two-bank line buffer and drains the chunk at the queue head:
// reads one entry, then decides on it, keeping one byte pending so the last
// emitted byte can carry run_end.
// ----------------------------------------------------------------------------
module tlf_back #(
	parameter int  LINE_WIDTH = tlf_pkg::LINE_WIDTH_DEF,
	parameter type cmd_t      = logic,
	parameter type mem_wr_t   = logic
) (
	input  logic     clk,
	input  logic     arst_n,
	input  mem_wr_t  mem_wr,
	input  cmd_t     head,
	input  logic     q_empty,
	output logic     pop,
	tlf_out_if.source out_ch
);

	localparam int AW        = $clog2(LINE_WIDTH);
	localparam int CW        = $clog2(LINE_WIDTH + 1);
	localparam int MEM_DEPTH = 2 * (2 ** AW);

	typedef enum logic [2:0] {
		B_IDLE,
		B_READ,
		B_EVAL,
		B_TAIL,
		B_DONE
	} state_t;

	logic [7:0]    mem [MEM_DEPTH];
	logic [7:0]    rdata_q;

	state_t        state_q;
	logic [CW-1:0] idx_q;
	logic [7:0]    pend_q;
	logic          pend_v_q;
	logic [7:0]    out_byte_q;
	logic          out_last_q;
	logic          out_v_q;

	logic          out_free;
	logic          out_load;
	logic          term;
	logic [7:0]    cur_byte;

	// Line buffer: front writes, read data registered here
	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			mem[mem_wr.addr] <= mem_wr.data;
		end
		if (state_q == B_READ) begin
			rdata_q <= mem[{head.bank, idx_q[AW-1:0]}];
		end
	end

	// Entry decode
	assign out_free = !out_v_q || out_ch.ready;
	assign out_load = out_free && (((state_q == B_EVAL) && pend_v_q) || (state_q == B_TAIL));
	assign term     = (idx_q == head.len) || (rdata_q == tlf_pkg::CH_NUL);
	assign cur_byte = (head.fold && (idx_q == head.fold_pos)) ? tlf_pkg::CH_NL : rdata_q;
	assign pop      = (state_q == B_DONE);

	assign out_ch.valid    = out_v_q;
	assign out_ch.out_byte = out_byte_q;
	assign out_ch.run_end  = out_last_q;

	// Drain sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			idx_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_v_q && out_ch.ready && !out_load) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						idx_q    <= '0;
						pend_v_q <= 1'b0;
						state_q  <= B_READ;
					end
				end
				B_READ: begin
					state_q <= B_EVAL;
				end
				B_EVAL: begin
					if (!pend_v_q || out_free) begin
						if (pend_v_q) begin
							out_v_q    <= 1'b1;
							out_byte_q <= pend_q;
							out_last_q <= term && !head.add_nl;
						end
						if (!term) begin
							// byte continues the chunk: hold it until the next one is known
							pend_q   <= cur_byte;
							pend_v_q <= 1'b1;
							idx_q    <= idx_q + CW'(1);
							state_q  <= B_READ;
						end else begin
							pend_v_q <= 1'b0;
							state_q  <= head.add_nl ? B_TAIL : B_DONE;
						end
					end
				end
				B_TAIL: begin
					// unfoldable full line gets an extra newline
					if (out_free) begin
						out_v_q    <= 1'b1;
						out_byte_q <= tlf_pkg::CH_NL;
						out_last_q <= 1'b1;
						state_q    <= B_DONE;
					end
				end
				B_DONE: begin
					state_q <= B_IDLE;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	a_done_nothing_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DONE) |-> !pend_v_q)
		else $error("chunk finished with a byte still pending");

	a_idx_within_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != B_IDLE) |-> (idx_q <= head.len))
		else $error("drain index ran past chunk length");

	a_tail_only_unfolded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_TAIL) |-> (head.add_nl && !head.fold))
		else $error("extra newline on a chunk that does not need one");

	a_drain_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != B_IDLE) |-> !q_empty)
		else $error("drain running without a command at the queue head");

endmodule

@@ src/text_line_folder_core.sv @@
// ----------------------------------------------------------------------------
// text_line_folder_core
// Fixed-width line folding of a byte stream: front end collects bytes into a
// two-bank line buffer, back end drains finished chunks with fold applied.
// ----------------------------------------------------------------------------
//  channel  | dir | fields            | notes
//  in_ch    | in  | mode, in_byte     | mode 0 data byte, mode 1 flush
//  out_ch   | out | out_byte, run_end | run_end on last byte of an input
//
// An input transfer is taken while fewer than two chunks await
// draining; the two buffer banks and the two-entry command queue set that.
// Draining passes each emitted byte through a registered buffer read, then
// decode; each chunk adds a start, a final read and decode, and a command
// release, with one more step when a newline is appended.
// Reset clears all control state at once; the buffer needs no clearing pass.
// A stalled output holds the drain; a busy drain stalls input only when both
// banks are taken.
module text_line_folder_core #(
	parameter int LINE_WIDTH = tlf_pkg::LINE_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tlf_in_if.sink    in_ch,
	tlf_out_if.source out_ch
);

	localparam int AW = $clog2(LINE_WIDTH);
	localparam int CW = $clog2(LINE_WIDTH + 1);

	typedef struct packed {
		logic          bank;
		logic [CW-1:0] len;
		logic          fold;
		logic [CW-1:0] fold_pos;
		logic          add_nl;
	} cmd_t;

	typedef struct packed {
		logic          en;
		logic [AW:0]   addr;
		logic [7:0]    data;
	} mem_wr_t;

	cmd_t    push_cmd;
	cmd_t    head;
	mem_wr_t mem_wr;
	logic    push;
	logic    pop;
	logic    q_full;
	logic    q_empty;

	// Front end: accept and classify
	tlf_front #(
		.LINE_WIDTH (LINE_WIDTH),
		.cmd_t      (cmd_t),
		.mem_wr_t   (mem_wr_t)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd),
		.mem_wr   (mem_wr)
	);

	// Chunk command queue
	tlf_cmdq #(
		.cmd_t (cmd_t)
	) u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	// Back end: drain with fold
	tlf_back #(
		.LINE_WIDTH (LINE_WIDTH),
		.cmd_t      (cmd_t),
		.mem_wr_t   (mem_wr_t)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.mem_wr  (mem_wr),
		.head    (head),
		.q_empty (q_empty),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks text_line_folder_core against a behavioral line folder kept in this
// bench. Byte streams of short lines, full foldable and unfoldable lines,
// NULs, flushes and noise are sent with random gaps on both channels. Every
// output transfer is compared with the oldest predicted byte.
// ----------------------------------------------------------------------------
module testbench;

	localparam int LINE_W = tlf_pkg::LINE_WIDTH_DEF;

	typedef struct packed {
		logic [7:0] ch;
		logic       eol;
	} fold_out_t;

	typedef enum int {
		LK_SHORT,
		LK_FOLD,
		LK_NOBLANK,
		LK_LEAD_BLANK,
		LK_NL_LAST,
		LK_NUL,
		LK_FLUSH,
		LK_NOISE
	} line_kind_e;

	logic clk;
	logic arst_n;

	tlf_in_if  in_ch ();
	tlf_out_if out_ch ();

	text_line_folder_core #(.LINE_WIDTH(LINE_W)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Shadow of the block's line buffer and chunk state
	logic [7:0] line_buf [LINE_W];
	int         fill       = 0;
	int         blank_at   = 0;
	bit         have_blank = 1'b0;
	fold_out_t  folded_q [$];
	fold_out_t  want;

	bit idle_on     = 1'b1;
	int hold_cycles = 0;
	int items_sent  = 0;
	int bytes_seen  = 0;
	int errors      = 0;

	// Clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic void clear_line();
		fill       = 0;
		blank_at   = 0;
		have_blank = 1'b0;
	endfunction

	// Queue the chunk up to its first NUL, optionally with a trailing newline
	function automatic void emit_chunk(bit add_nl);
		int base;
		base = folded_q.size();
		for (int i = 0; i < fill; i++) begin
			if (line_buf[i] == tlf_pkg::CH_NUL)
				break;
			folded_q.push_back('{ch: line_buf[i], eol: 1'b0});
		end
		if (add_nl)
			folded_q.push_back('{ch: tlf_pkg::CH_NL, eol: 1'b0});
		if (folded_q.size() > base)
			folded_q[folded_q.size() - 1].eol = 1'b1;
	endfunction

	// Expected output bytes caused by one accepted input transfer
	function automatic void fold_predict(logic m, logic [7:0] b);
		if (m == tlf_pkg::MODE_FLUSH) begin
			emit_chunk(1'b0);
			clear_line();
			return;
		end
		if (fill >= LINE_W)
			clear_line();
		line_buf[fill] = b;
		if ((b == tlf_pkg::CH_SPACE || b == tlf_pkg::CH_TAB) && fill >= 1) begin
			blank_at   = fill;
			have_blank = 1'b1;
		end
		fill++;
		if (b != tlf_pkg::CH_NL && fill < LINE_W)
			return;
		if (fill < LINE_W) begin
			emit_chunk(1'b0);
		end else if (have_blank) begin
			line_buf[blank_at] = tlf_pkg::CH_NL;
			emit_chunk(1'b0);
		end else begin
			emit_chunk(1'b1);
		end
		clear_line();
	endfunction

	// Any byte but a blank, newline or NUL
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(1, 255));
		while (b == tlf_pkg::CH_TAB || b == tlf_pkg::CH_NL || b == tlf_pkg::CH_SPACE);
		return b;
	endfunction

	// Text byte; one in blank_odds is a space or tab (never when zero)
	function automatic logic [7:0] pick_text(int blank_odds);
		if (blank_odds > 0 && $urandom_range(0, blank_odds - 1) == 0)
			return $urandom_range(0, 1) ? tlf_pkg::CH_SPACE : tlf_pkg::CH_TAB;
		return plain_byte();
	endfunction

	// Offer one item and hold it until the transfer happens
	task automatic send_item(logic m, logic [7:0] b);
		int gap;
		bit took;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 16);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.mode    <= m;
		in_ch.in_byte <= b;
		do begin
			@(negedge clk);
			took = in_ch.ready;
			@(posedge clk);
		end while (!took);
		fold_predict(m, b);
		items_sent++;
	endtask

	task automatic release_input();
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (folded_q.size() != 0)
			@(posedge clk);
	endtask

	// One well-formed run of text of the given kind, random content
	task automatic send_text_run(line_kind_e kind);
		int len;
		int nul_at;
		bit full;
		case (kind)
			LK_SHORT: begin
				len = $urandom_range(0, LINE_W - 2);
				repeat (len) send_item(tlf_pkg::MODE_DATA, pick_text(5));
				send_item(tlf_pkg::MODE_DATA, tlf_pkg::CH_NL);
			end
			LK_FOLD: begin
				repeat (LINE_W) send_item(tlf_pkg::MODE_DATA, pick_text(6));
			end
			LK_NOBLANK: begin
				repeat (LINE_W) send_item(tlf_pkg::MODE_DATA, pick_text(0));
			end
			LK_LEAD_BLANK: begin
				// only blank sits at index zero, so no fold point
				send_item(tlf_pkg::MODE_DATA,
				          $urandom_range(0, 1) ? tlf_pkg::CH_SPACE : tlf_pkg::CH_TAB);
				repeat (LINE_W - 1) send_item(tlf_pkg::MODE_DATA, pick_text(0));
			end
			LK_NL_LAST: begin
				repeat (LINE_W - 1) send_item(tlf_pkg::MODE_DATA, pick_text(8));
				send_item(tlf_pkg::MODE_DATA, tlf_pkg::CH_NL);
			end
			LK_NUL: begin
				full   = $urandom_range(0, 1);
				len    = full ? LINE_W : $urandom_range(1, LINE_W - 2);
				nul_at = $urandom_range(0, len - 1);
				for (int i = 0; i < len; i++)
					send_item(tlf_pkg::MODE_DATA,
					          (i == nul_at) ? tlf_pkg::CH_NUL : pick_text(0));
				if (!full)
					send_item(tlf_pkg::MODE_DATA, tlf_pkg::CH_NL);
			end
			LK_FLUSH: begin
				len = $urandom_range(0, LINE_W - 2);
				repeat (len) send_item(tlf_pkg::MODE_DATA, pick_text(5));
				send_item(tlf_pkg::MODE_FLUSH, 8'($urandom_range(0, 255)));
			end
			default: begin
				repeat ($urandom_range(1, 8))
					send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
			end
		endcase
	endtask

	// Short chunks, extreme bytes, NUL at start and inside, empty flushes
	task automatic test_short_chunks();
		send_item(tlf_pkg::MODE_FLUSH, 8'hFF);
		send_item(tlf_pkg::MODE_DATA, 8'h61);
		send_item(tlf_pkg::MODE_DATA, 8'hFF);
		send_item(tlf_pkg::MODE_DATA, 8'h80);
		send_item(tlf_pkg::MODE_DATA, tlf_pkg::CH_NL);
		send_item(tlf_pkg::MODE_DATA, tlf_pkg::CH_NUL);
		send_item(tlf_pkg::MODE_DATA, 8'h78);
		send_item(tlf_pkg::MODE_DATA, tlf_pkg::CH_NL);
		send_item(tlf_pkg::MODE_DATA, 8'h71);
		send_item(tlf_pkg::MODE_DATA, tlf_pkg::CH_NUL);
		send_item(tlf_pkg::MODE_DATA, 8'h7A);
		send_item(tlf_pkg::MODE_FLUSH, 8'h00);
		send_item(tlf_pkg::MODE_DATA, tlf_pkg::CH_TAB);
		send_item(tlf_pkg::MODE_DATA, tlf_pkg::CH_SPACE);
		send_item(tlf_pkg::MODE_DATA, 8'h6B);
		send_item(tlf_pkg::MODE_FLUSH, 8'h55);
		send_item(tlf_pkg::MODE_DATA, tlf_pkg::CH_NL);
		send_item(tlf_pkg::MODE_FLUSH, 8'hAA);
		release_input();
	endtask

	// Every kind once, then random kinds with idling switched per run
	task automatic test_random_text(int n_items);
		int start;
		start = items_sent;
		for (int k = LK_SHORT; k <= LK_NOISE; k++)
			send_text_run(line_kind_e'(k));
		while (items_sent - start < n_items) begin
			idle_on = ($urandom_range(0, 3) != 0);
			send_text_run(line_kind_e'($urandom_range(LK_SHORT, LK_NOISE)));
		end
		idle_on = 1'b1;
		release_input();
	endtask

	// Output held off long enough that both banks fill and input stalls
	task automatic test_output_stall();
		hold_cycles = 300;
		repeat (4) begin
			repeat (3) send_item(tlf_pkg::MODE_DATA, plain_byte());
			send_item(tlf_pkg::MODE_DATA, tlf_pkg::CH_NL);
		end
		release_input();
	endtask

	// Sender pauses until everything queued has come out
	task automatic test_drain_pause();
		repeat (4) send_item(tlf_pkg::MODE_DATA, plain_byte());
		send_item(tlf_pkg::MODE_DATA, tlf_pkg::CH_NL);
		release_input();
		wait_drained();
		repeat (3) send_item(tlf_pkg::MODE_DATA, pick_text(2));
		send_item(tlf_pkg::MODE_FLUSH, 8'h00);
		release_input();
	endtask

	// Last stretch at full rate on both sides
	task automatic test_quiet_tail();
		idle_on = 1'b0;
		send_text_run(LK_FOLD);
		release_input();
	endtask

	// Output ready: long hold-offs on request, random stall bursts otherwise
	initial begin : out_ready_ctl
		int n;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				n           = hold_cycles;
				hold_cycles = 0;
				out_ch.ready <= 1'b0;
				repeat (n - 1) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 16);
				out_ch.ready <= 1'b0;
				repeat (n - 1) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Output check: values are settled at the falling edge before the transfer
	always @(negedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			bytes_seen++;
			if (folded_q.size() == 0) begin
				$error("unexpected output: out_byte=%h run_end=%b",
				       out_ch.out_byte, out_ch.run_end);
				errors++;
			end else begin
				want = folded_q.pop_front();
				if (out_ch.out_byte !== want.ch) begin
					$error("out_byte: expected %h, got %h", want.ch, out_ch.out_byte);
					errors++;
				end
				if (out_ch.run_end !== want.eol) begin
					$error("run_end: expected %b, got %b", want.eol, out_ch.run_end);
					errors++;
				end
			end
		end
	end

	// Watchdog
	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end

	// Main sequence
	initial begin
		arst_n        = 1'b0;
		in_ch.valid   <= 1'b0;
		in_ch.mode    <= tlf_pkg::MODE_DATA;
		in_ch.in_byte <= 8'h00;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_chunks();
		test_random_text(300);
		test_output_stall();
		test_drain_pause();
		test_quiet_tail();

		wait_drained();
		if (folded_q.size() != 0) begin
			$error("%0d expected output bytes never arrived", folded_q.size());
			errors++;
		end
		repeat (4 * LINE_W) @(posedge clk);

		$display("Sent %0d input transfers, checked %0d output transfers:", items_sent,
		         bytes_seen);
		$display("short, folded, unfoldable, NUL, flush and stalled-output lines.");
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
